@@ design/dpram_word_to_double_converter_macros.svh @@
// Assertion macros for the DPRAM word decoder
`ifndef DPRAM_WORD_TO_DOUBLE_CONVERTER_MACROS_SVH
`define DPRAM_WORD_TO_DOUBLE_CONVERTER_MACROS_SVH

// Same-cycle implication, disabled in reset
`define DWDC_ASSERT_NOW(label, ck, rs, ante, cons) \
  label: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("dwdc check failed");

// Next-cycle implication, disabled in reset
`define DWDC_ASSERT_NEXT(label, ck, rs, ante, cons) \
  label: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("dwdc check failed");

`endif

@@ design/dwdc_pkg.sv @@
// ---------------------------------------------------------------------------
// dwdc_pkg
// Types and constants shared by the DPRAM word decoder.
// ---------------------------------------------------------------------------
package dwdc_pkg;

  typedef enum logic [2:0] {
    FUNC_U16     = 3'd0,
    FUNC_U24     = 3'd1,
    FUNC_S24     = 3'd2,
    FUNC_FLOAT32 = 3'd3,
    FUNC_FIXED48 = 3'd4,
    FUNC_FLOAT48 = 3'd5
  } func_t;

  typedef struct packed {
    logic [2:0]  func;
    logic [31:0] low_word;
    logic [23:0] high_word;
  } dwdc_item_t;

  localparam logic [63:0] SIGN_BIT  = 64'h8000_0000_0000_0000;
  localparam logic [63:0] FRAC_MASK = 64'h000F_FFFF_FFFF_FFFF;
  localparam logic [63:0] EXP_INF   = 64'h7FF0_0000_0000_0000;
  localparam logic signed [13:0] F48_BIAS = 14'sd2082;

endpackage

@@ design/dwdc_conv.sv @@
// ---------------------------------------------------------------------------
// dwdc_conv
// Combinational decode of one DPRAM word into a 64-bit integer or double.
// ---------------------------------------------------------------------------
module dwdc_conv
  import dwdc_pkg::*;
(
  input  dwdc_item_t  item,
  output logic [63:0] result_bits
);

  logic        neg;
  logic [47:0] mag;
  logic signed [13:0] e;
  logic [5:0]  top;
  logic signed [13:0] ue;
  logic signed [13:0] sh;
  logic [63:0] packed_dbl;
  logic [63:0] s;
  logic [47:0] raw;
  logic [35:0] m48;
  logic signed [13:0] e48;
  logic [7:0]  ex32;
  logic [22:0] fr32;
  logic [10:0] exp_d;

  assign raw  = {item.high_word, item.low_word[23:0]};
  assign m48  = {item.high_word[11:0], item.low_word[23:0]};
  assign e48  = $signed({2'b00, item.high_word[23:12]}) - F48_BIAS;
  assign ex32 = item.low_word[30:23];
  assign fr32 = item.low_word[22:0];

  // pick the operand of the shared normaliser
  always_comb begin
    neg = 1'b0;
    mag = '0;
    e   = '0;
    case (item.func)
      FUNC_FLOAT32: begin
        neg = item.low_word[31];
        mag = {25'd0, fr32};
        e   = -14'sd149;
      end
      FUNC_FIXED48: begin
        neg = item.high_word[23];
        mag = neg ? (48'd0 - raw) : raw;
      end
      FUNC_FLOAT48: begin
        mag = {12'd0, m48};
        e   = e48;
      end
      default: begin
        neg = 1'b0;
      end
    endcase
  end

  // leading one position
  always_comb begin
    top = '0;
    for (int i = 0; i < 48; i++) begin
      if (mag[i]) top = 6'(i);
    end
  end

  assign s  = neg ? SIGN_BIT : 64'd0;
  assign ue = $signed({8'd0, top}) + e;
  assign sh = e + 14'sd1074;
  assign exp_d = 11'(ue + 14'sd1023);

  always_comb begin
    if (mag == '0) begin
      packed_dbl = s;
    end else if (ue > 14'sd1023) begin
      packed_dbl = s | EXP_INF;
    end else if (ue >= -14'sd1022) begin
      packed_dbl = s | {1'b0, exp_d, 52'd0}
                 | (({16'd0, mag} << (6'd52 - top)) & FRAC_MASK);
    end else if (sh < 14'sd0) begin
      packed_dbl = s;
    end else begin
      packed_dbl = s | ({16'd0, mag} << sh[5:0]);
    end
  end

  always_comb begin
    case (item.func)
      FUNC_U16: result_bits = {48'd0, item.low_word[15:0]};
      FUNC_U24: result_bits = {40'd0, item.low_word[23:0]};
      FUNC_S24: result_bits = {{40{item.low_word[23]}}, item.low_word[23:0]};
      FUNC_FLOAT32: begin
        if (ex32 == 8'hFF) begin
          if (fr32 == '0) result_bits = s | EXP_INF;
          else result_bits = s | EXP_INF | {12'd0, 1'b1, fr32[21:0], 29'd0};
        end else if (ex32 == 8'h00) begin
          result_bits = packed_dbl;
        end else begin
          result_bits = s | {1'b0, 3'd0, ex32, 52'd0} + {1'b0, 11'd896, 52'd0}
                      | {12'd0, fr32, 29'd0};
        end
      end
      FUNC_FIXED48: result_bits = packed_dbl;
      FUNC_FLOAT48: begin
        if (m48 == '0 || e48 < -14'sd1074) result_bits = 64'd0;
        else if (e48 > 14'sd1023) result_bits = EXP_INF;
        else result_bits = packed_dbl;
      end
      default: result_bits = 64'd0;
    endcase
  end

endmodule

@@ design/dpram_word_to_double_converter.sv @@
// ---------------------------------------------------------------------------
// dpram_word_to_double_converter
// Decodes DPRAM words into 64-bit integers or IEEE754 doubles.
// ---------------------------------------------------------------------------
//  channel | dir | tdata                         | tuser
//  s_*     | in  | [31:0] low_word [55:32] high  | [2:0] func
//  m_*     | out | [63:0] result_bits            | -
//
//  One word per cycle while m_tready is high; two registers (input register, result register).
//  The decoder sits between the two registers as one pass of logic.
//  rst clears both valid flags; payload registers are not reset.
//  A stall on m_tready holds the result and backs up into s_tready.
module dpram_word_to_double_converter
  import dwdc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,   // [31:0] low_word, [55:32] high_word, rest zero
  input  logic [7:0]  s_tuser,   // [2:0] func, rest zero
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [63:0] m_tdata    // [63:0] result_bits
);

`include "dpram_word_to_double_converter_macros.svh"

  dwdc_item_t  item;
  logic        item_valid;
  logic        item_ready;
  logic [63:0] conv_bits;
  logic        bad_func;

  assign item_ready = !m_tvalid || m_tready;
  assign s_tready   = !item_valid || item_ready;
  assign bad_func   = item.func > FUNC_FLOAT48;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
      m_tvalid   <= 1'b0;
    end else begin
      if (s_tready) item_valid <= s_tvalid;
      if (item_ready) m_tvalid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      item.func      <= s_tuser[2:0];
      item.low_word  <= s_tdata[31:0];
      item.high_word <= s_tdata[55:32];
    end
    if (item_ready && item_valid) m_tdata <= conv_bits;
  end

  dwdc_conv u_conv (
    .item        (item),
    .result_bits (conv_bits)
  );

  `DWDC_ASSERT_NOW(a_backpressure, clk, rst, item_valid && m_tvalid && !m_tready, !s_tready)
  `DWDC_ASSERT_NEXT(a_accept_loads, clk, rst, s_tvalid && s_tready, item_valid)
  `DWDC_ASSERT_NEXT(a_bad_func_zero, clk, rst, item_valid && item_ready && bad_func, m_tdata == 64'd0)

endmodule

@@ tb/dpram_word_to_double_converter_tb.sv @@
// ---------------------------------------------------------------------------
// dpram_word_to_double_converter_tb
// Streams DPRAM words of every format through the decoder with random gaps
// on both sides and checks each result against a local decoding model.
// ---------------------------------------------------------------------------
module dpram_word_to_double_converter_tb;
  import dwdc_pkg::*;

  localparam logic [63:0] QUIET_BIT = 64'h0008_0000_0000_0000;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [63:0] s_tdata;
  logic [7:0]  s_tuser;
  logic        m_tvalid;
  logic        m_tready;
  logic [63:0] m_tdata;

  dpram_word_to_double_converter u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  dwdc_item_t  pending_words[$];
  logic [63:0] expected_results[$];
  int          mismatches;
  int          results_seen;
  int          words_sent;
  int          fmt_count[8];
  bit          stim_done;
  bit          quiet_tail;
  bit          hold_send;
  bit          in_taken;

  // Exact double of (-1)^neg * mag * 2^e, mag below 2^53
  function automatic logic [63:0] pack_double(bit neg, logic [63:0] mag, int e);
    logic [63:0] s;
    int          top;
    int          ue;
    int          sh;
    s = neg ? SIGN_BIT : 64'd0;
    if (mag == 0) return s;
    top = 0;
    for (int i = 0; i < 64; i++) if (mag[i]) top = i;
    ue = top + e;
    if (ue > 1023) return s | EXP_INF;
    if (ue >= -1022)
      return s | (64'(ue + 1023) << 52) | ((mag << (52 - top)) & FRAC_MASK);
    sh = e + 1074;
    if (sh < 0) return s;
    return s | (mag << sh);
  endfunction

  function automatic logic [63:0] decode_word(dwdc_item_t w);
    logic [63:0] raw;
    logic [63:0] mag;
    logic [7:0]  ex;
    int          e;
    bit          neg;
    case (w.func)
      FUNC_U16:  return {48'd0, w.low_word[15:0]};
      FUNC_U24:  return {40'd0, w.low_word[23:0]};
      FUNC_S24:  return {{40{w.low_word[23]}}, w.low_word[23:0]};
      FUNC_FLOAT32: begin
        neg = w.low_word[31];
        ex  = w.low_word[30:23];
        raw = {41'd0, w.low_word[22:0]};
        if (ex == 8'hff) begin
          if (raw == 0) return {neg, 63'd0} | EXP_INF;
          return {neg, 63'd0} | EXP_INF | QUIET_BIT | (raw << 29);
        end
        if (ex == 0) return pack_double(neg, raw, -149);
        return {neg, 63'd0} | (64'(ex + 896) << 52) | (raw << 29);
      end
      FUNC_FIXED48: begin
        raw = {16'd0, w.high_word, w.low_word[23:0]};
        neg = w.high_word[23];
        mag = neg ? ((64'h1_0000_0000_0000 - raw) & 64'hFFFF_FFFF_FFFF) : raw;
        if (neg && mag == 0) mag = 64'h8000_0000_0000;
        return pack_double(neg, mag, 0);
      end
      FUNC_FLOAT48: begin
        mag = {28'd0, w.high_word[11:0], w.low_word[23:0]};
        e   = int'(w.high_word[23:12]) - int'(F48_BIAS);
        if (mag == 0 || e < -1074) return 64'd0;
        if (e > 1023) return EXP_INF;
        return pack_double(1'b0, mag, e);
      end
      default: return 64'd0;
    endcase
  endfunction

  function automatic dwdc_item_t random_word();
    dwdc_item_t w;
    w.func      = 3'($urandom_range(0, 7));
    w.low_word  = $urandom;
    w.high_word = 24'($urandom);
    case ($urandom_range(0, 5))
      0: w.low_word[30:23] = $urandom_range(0, 1) ? 8'hff : 8'h00;
      // bias the float48 exponent around the normal, subnormal and overflow edges
      1: w.high_word[23:12] = 12'(2082 + $urandom_range(0, 2200) - 1110);
      2: w.high_word[23:12] = 12'(2082 - 1074 - 40 + $urandom_range(0, 80));
      3: w.high_word[11:0]  = 12'($urandom_range(0, 3));
      default: ;
    endcase
    return w;
  endfunction

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Note whether the word on offer went in at the last rising edge
  always @(posedge clk) begin
    in_taken <= s_tvalid && s_tready;
  end

  // Driver: present words at the falling edge, idle in random bursts
  int send_gap;
  always @(negedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      send_gap <= 0;
    end else if (!s_tvalid || in_taken) begin
      if (send_gap > 0) begin
        s_tvalid <= 1'b0;
        send_gap <= send_gap - 1;
      end else if (!quiet_tail && $urandom_range(0, 9) == 0) begin
        s_tvalid <= 1'b0;
        send_gap <= $urandom_range(1, 17) - 1;
      end else if (pending_words.size() > 0 && !hold_send) begin
        s_tvalid <= 1'b1;
        s_tdata  <= {8'd0, pending_words[0].high_word, pending_words[0].low_word};
        s_tuser  <= {5'd0, pending_words[0].func};
        void'(pending_words.pop_front());
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  int recv_gap;
  always @(negedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
      recv_gap <= 0;
    end else if (recv_gap > 0) begin
      m_tready <= 1'b0;
      recv_gap <= recv_gap - 1;
    end else if (!quiet_tail && $urandom_range(0, 9) == 0) begin
      m_tready <= 1'b0;
      recv_gap <= $urandom_range(1, 17) - 1;
    end else begin
      m_tready <= 1'b1;
    end
  end

  // Monitor: predict on accepted input, check on accepted output
  always @(posedge clk) begin
    dwdc_item_t w;
    logic [63:0] want;
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        w.func      = s_tuser[2:0];
        w.low_word  = s_tdata[31:0];
        w.high_word = s_tdata[55:32];
        expected_results.push_back(decode_word(w));
        fmt_count[w.func]++;
        words_sent++;
      end
      if (m_tvalid && m_tready) begin
        results_seen++;
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result %h", m_tdata);
        end else begin
          want = expected_results.pop_front();
          if (m_tdata !== want) begin
            mismatches++;
            if (mismatches <= 10)
              $display("result_bits mismatch: expected %h actual %h", want, m_tdata);
          end
        end
      end
    end
  end

  task automatic queue_word(logic [2:0] f, logic [31:0] lo, logic [23:0] hi);
    dwdc_item_t w;
    w.func = f;
    w.low_word = lo;
    w.high_word = hi;
    pending_words.push_back(w);
  endtask

  task automatic wait_drained();
    while (pending_words.size() > 0 || s_tvalid || expected_results.size() > 0)
      @(posedge clk);
  endtask

  initial begin
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = '0;
    m_tready = 1'b0;
    mismatches = 0;
    results_seen = 0;
    words_sent = 0;
    stim_done = 1'b0;
    quiet_tail = 1'b0;
    hold_send = 1'b0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // directed edges of every format
    queue_word(FUNC_U16, 32'hFFFF_FFFF, 24'hFFFFFF);
    queue_word(FUNC_U24, 32'hFFFF_FFFF, 24'h000000);
    queue_word(FUNC_S24, 32'h0080_0000, 24'h0);
    queue_word(FUNC_S24, 32'hFF7F_FFFF, 24'h0);
    queue_word(FUNC_FLOAT32, 32'h8000_0000, 24'h0);
    queue_word(FUNC_FLOAT32, 32'hFF80_0000, 24'h0);
    queue_word(FUNC_FLOAT32, 32'h7F80_0001, 24'h0);
    queue_word(FUNC_FLOAT32, 32'h0000_0001, 24'h0);
    queue_word(FUNC_FLOAT32, 32'h807F_FFFF, 24'h0);
    queue_word(FUNC_FLOAT32, 32'h7F7F_FFFF, 24'h0);
    queue_word(FUNC_FIXED48, 32'h0000_0000, 24'h000000);
    queue_word(FUNC_FIXED48, 32'hFF00_0000, 24'h800000);
    queue_word(FUNC_FIXED48, 32'h00FF_FFFF, 24'h7FFFFF);
    queue_word(FUNC_FIXED48, 32'hFFFF_FFFF, 24'hFFFFFF);
    queue_word(FUNC_FLOAT48, 32'h0000_0000, 24'h823000);
    queue_word(FUNC_FLOAT48, 32'h0000_0001, 24'h3EF000);
    queue_word(FUNC_FLOAT48, 32'h0000_0001, 24'h3F0000);
    queue_word(FUNC_FLOAT48, 32'hFFFF_FFFF, 24'hFFFFFF);
    queue_word(FUNC_FLOAT48, 32'h00FF_FFFF, 24'hC01FFF);
    queue_word(FUNC_FLOAT48, 32'h0000_0001, 24'h822000);
    queue_word(3'd6, 32'hFFFF_FFFF, 24'hFFFFFF);
    queue_word(3'd7, 32'h1234_5678, 24'h9ABCDE);

    // wait until the directed words have all come back before queuing random ones
    wait_drained();
    for (int i = 0; i < 400; i++) begin
      pending_words.push_back(random_word());
      if (i == 200) begin
        wait_drained();
        hold_send = 1'b0;
      end
      if (i == 320) quiet_tail = 1'b1;
    end
    wait_drained();
    repeat (10) @(posedge clk);
    stim_done = 1'b1;
    $display("words %0d results %0d; per format u16 %0d u24 %0d s24 %0d",
             words_sent, results_seen, fmt_count[0], fmt_count[1], fmt_count[2]);
    $display("float32 %0d fixed48 %0d float48 %0d undefined selector %0d",
             fmt_count[3], fmt_count[4], fmt_count[5], fmt_count[6] + fmt_count[7]);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
